@@ design/mtp_pkg.sv @@
`timescale 1ns / 1ps

package mtp_pkg;

	localparam int TAG_SIZE_W   = 25;
	localparam int HDR_LEN_W    = 24;
	localparam int POS_W        = 32;
	localparam int LEN_W        = 16;
	localparam int MAX_CHUNKS   = 63;
	localparam int CHUNK_CNT_W  = $clog2(MAX_CHUNKS + 1);
	localparam int LIM_W        = LEN_W + CHUNK_CNT_W;
	localparam int SUM_W        = TAG_SIZE_W + 1;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 16;
	localparam int IN_DATA_W    = 56;
	localparam int IN_USER_W    = 2;
	localparam int OUT_DATA_W   = 48;
	localparam int OUT_USER_W   = 2;

	localparam logic [LEN_W-1:0] MAX_PKT_RESET = 16'd15360;
	localparam logic [LEN_W-1:0] THR_RESET     = 16'd8192;
	localparam logic [LIM_W-1:0] LIM_RESET     = LIM_W'(MAX_PKT_RESET) * LIM_W'(MAX_CHUNKS);

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PKT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_THR = 1'd1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_FLUSH,
		S_REFLUSH,
		S_CHUNK,
		S_ERR,
		S_HDR
	} state_t;

	typedef enum logic [1:0] {
		M_CMD,
		M_ALONE,
		M_THR
	} mode_t;

	typedef enum logic [1:0] {
		EM_BUF,
		EM_CHUNK,
		EM_ERR
	} emit_sel_t;

	typedef enum logic [1:0] {
		POS_NONE,
		POS_BUF,
		POS_HDR,
		POS_CHUNK
	} pos_sel_t;

	typedef enum logic [1:0] {
		BUF_KEEP,
		BUF_CLEAR,
		BUF_SIZE,
		BUF_SUM
	} buf_op_t;

	typedef struct packed {
		logic      load;
		logic      emit;
		emit_sel_t emit_sel;
		logic      last;
		pos_sel_t  pos_sel;
		buf_op_t   buf_op;
		logic      set_ks;
		logic      chunk_step;
	} ctl_cmd_t;

	typedef struct packed {
		logic func;
		logic key;
		logic buf_nz;
		logic sum_gt_max;
		logic sum_gt_thr;
		logic size_gt_thr;
		logic size_nz;
		logic too_big;
		logic left_gt_max;
		logic left_nz;
		logic out_free;
	} dp_status_t;

endpackage

@@ design/mtp_ctrl.sv @@
`timescale 1ns / 1ps

module mtp_ctrl import mtp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t st,
	output ctl_cmd_t   cmd
);

	state_t state_q, state_d;
	mode_t  mode_q, mode_d;
	state_t after_alone;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= M_CMD;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
		end
	end

	always_comb begin
		if (st.too_big) begin
			after_alone = S_ERR;
		end else if (st.size_nz) begin
			after_alone = S_CHUNK;
		end else begin
			after_alone = S_IDLE;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		mode_d  = mode_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (st.func) begin
					mode_d  = M_CMD;
					state_d = st.buf_nz ? S_FLUSH : S_IDLE;
				end else if (st.key || st.sum_gt_max) begin
					mode_d  = M_ALONE;
					state_d = st.buf_nz ? S_FLUSH : after_alone;
				end else if (st.sum_gt_thr) begin
					mode_d = M_THR;
					if (st.buf_nz) begin
						state_d = S_FLUSH;
					end else begin
						state_d = st.size_gt_thr ? S_REFLUSH : S_IDLE;
					end
				end else begin
					state_d = S_IDLE;
				end
			end
			S_FLUSH: begin
				if (st.out_free) begin
					case (mode_q)
						M_CMD:   state_d = S_HDR;
						M_THR:   state_d = st.size_gt_thr ? S_REFLUSH : S_IDLE;
						M_ALONE: state_d = after_alone;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_REFLUSH: begin
				if (st.out_free) begin
					state_d = S_IDLE;
				end
			end
			S_CHUNK: begin
				if (st.out_free && !st.left_gt_max) begin
					state_d = S_IDLE;
				end
			end
			S_ERR: begin
				if (st.out_free) begin
					state_d = S_IDLE;
				end
			end
			S_HDR: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready       = (state_q == S_IDLE);
		cmd            = '0;
		cmd.emit_sel   = EM_BUF;
		cmd.pos_sel    = POS_NONE;
		cmd.buf_op     = BUF_KEEP;
		case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
			end
			S_DECIDE: begin
				if (st.func) begin
					if (!st.buf_nz) begin
						cmd.pos_sel = POS_HDR;
					end
				end else if (st.key || st.sum_gt_max) begin
					cmd.set_ks = st.key;
				end else if (st.sum_gt_thr) begin
					if (!st.buf_nz) begin
						cmd.buf_op = BUF_SIZE;
					end
				end else begin
					cmd.buf_op = BUF_SUM;
				end
			end
			S_FLUSH: begin
				if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_BUF;
					cmd.pos_sel  = POS_BUF;
					cmd.buf_op   = (mode_q == M_THR) ? BUF_SIZE : BUF_CLEAR;
					case (mode_q)
						M_CMD:   cmd.last = 1'b1;
						M_THR:   cmd.last = !st.size_gt_thr;
						M_ALONE: cmd.last = !st.too_big && !st.size_nz;
						default: cmd.last = 1'b1;
					endcase
				end
			end
			S_REFLUSH: begin
				if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_BUF;
					cmd.pos_sel  = POS_BUF;
					cmd.buf_op   = BUF_CLEAR;
					cmd.last     = 1'b1;
				end
			end
			S_CHUNK: begin
				if (st.out_free) begin
					cmd.emit       = 1'b1;
					cmd.emit_sel   = EM_CHUNK;
					cmd.pos_sel    = POS_CHUNK;
					cmd.chunk_step = 1'b1;
					cmd.last       = !st.left_gt_max;
				end
			end
			S_ERR: begin
				if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_ERR;
					cmd.last     = 1'b1;
				end
			end
			S_HDR: begin
				cmd.pos_sel = POS_HDR;
			end
			default: begin
				cmd.load = 1'b0;
			end
		endcase
	end

	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> st.out_free)
		else $error("result issued while output register is occupied");

	a_chunk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHUNK) |-> st.left_nz)
		else $error("chunk state entered with nothing left to send");

	a_accept_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_DECIDE))
		else $error("accepted transaction not followed by decision");

endmodule

@@ design/mtp_dp.sv @@
`timescale 1ns / 1ps

module mtp_dp import mtp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctl_cmd_t              cmd,
	output dp_status_t            st,
	input  logic                  in_func,
	input  logic [TAG_SIZE_W-1:0] in_tag_size,
	input  logic                  in_is_keyframe,
	input  logic [HDR_LEN_W-1:0]  in_header_len,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [POS_W-1:0]      out_packet_pos,
	output logic [LEN_W-1:0]      out_packet_len,
	output logic                  out_continuation,
	output logic                  out_is_last,
	output logic                  out_size_error
);

	logic [LEN_W-1:0]      max_q;
	logic [LEN_W-1:0]      thr_q;
	logic [LIM_W-1:0]      lim_q;
	logic [POS_W-1:0]      pos_q;
	logic [LEN_W-1:0]      buf_q;
	logic                  ks_q;
	logic                  func_q;
	logic                  key_q;
	logic [TAG_SIZE_W-1:0] size_q;
	logic [TAG_SIZE_W-1:0] left_q;
	logic [HDR_LEN_W-1:0]  hlen_q;
	logic                  first_q;
	logic                  ovalid_q;

	logic [LEN_W-1:0]      max_eff;
	logic [SUM_W-1:0]      sum;
	logic [LEN_W-1:0]      chunk_len;
	logic [POS_W-1:0]      pos_add;

	assign max_eff   = (cfg_wdata == '0) ? LEN_W'(1) : cfg_wdata;
	assign sum       = SUM_W'(buf_q) + SUM_W'(size_q);
	assign chunk_len = st.left_gt_max ? max_q : left_q[LEN_W-1:0];

	always_comb begin
		case (cmd.pos_sel)
			POS_BUF:   pos_add = POS_W'(buf_q);
			POS_HDR:   pos_add = POS_W'(hlen_q);
			POS_CHUNK: pos_add = POS_W'(chunk_len);
			default:   pos_add = '0;
		endcase
	end

	always_comb begin
		st.func        = func_q;
		st.key         = key_q;
		st.buf_nz      = (buf_q != '0);
		st.sum_gt_max  = (sum > SUM_W'(max_q));
		st.sum_gt_thr  = (sum > SUM_W'(thr_q));
		st.size_gt_thr = (size_q > TAG_SIZE_W'(thr_q));
		st.size_nz     = (size_q != '0);
		st.too_big     = (size_q > TAG_SIZE_W'(lim_q));
		st.left_gt_max = (left_q > TAG_SIZE_W'(max_q));
		st.left_nz     = (left_q != '0);
		st.out_free    = !ovalid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q    <= MAX_PKT_RESET;
			thr_q    <= THR_RESET;
			lim_q    <= LIM_RESET;
			pos_q    <= '0;
			buf_q    <= '0;
			ks_q     <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_MAX_PKT: begin
						max_q <= max_eff;
						lim_q <= LIM_W'(max_eff) * LIM_W'(MAX_CHUNKS);
					end
					CFG_FLUSH_THR: thr_q <= cfg_wdata;
					default: thr_q <= thr_q;
				endcase
			end
			pos_q <= pos_q + pos_add;
			case (cmd.buf_op)
				BUF_CLEAR: buf_q <= '0;
				BUF_SIZE:  buf_q <= size_q[LEN_W-1:0];
				BUF_SUM:   buf_q <= sum[LEN_W-1:0];
				default:   buf_q <= buf_q;
			endcase
			if (cmd.set_ks) begin
				ks_q <= 1'b1;
			end
			if (cmd.emit) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= in_func;
			key_q   <= in_is_keyframe;
			size_q  <= in_tag_size;
			left_q  <= in_tag_size;
			hlen_q  <= in_header_len;
			first_q <= 1'b1;
		end else if (cmd.chunk_step) begin
			left_q  <= left_q - TAG_SIZE_W'(chunk_len);
			first_q <= 1'b0;
		end
		if (cmd.emit) begin
			out_packet_pos <= pos_q;
			out_is_last    <= cmd.last;
			case (cmd.emit_sel)
				EM_BUF: begin
					out_packet_len   <= buf_q;
					out_continuation <= ks_q;
					out_size_error   <= 1'b0;
				end
				EM_CHUNK: begin
					out_packet_len   <= chunk_len;
					out_continuation <= ks_q && !(first_q && key_q);
					out_size_error   <= 1'b0;
				end
				default: begin
					out_packet_len   <= '0;
					out_continuation <= 1'b0;
					out_size_error   <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid = ovalid_q;

endmodule

@@ design/media_tag_packetizer_core.sv @@
`timescale 1ns / 1ps

// Media tag packetizer: turns a stream of tag descriptors into packet
// descriptors (position, length, continuation, error).
// Input channel s_axis: one transaction per put-tag or flush command.
// Output channel m_axis: zero to 64 packet transactions per input,
// tlast marks the final one of each input.
// Config channel: cfg_index 0 = max packet bytes, 1 = flush threshold;
// always ready, write only while no input is in flight.
// Timing: an input is taken in the idle state, decided in the next cycle,
// then the emit sequencer issues each of its results in turn; the first
// is registered in the output register by the state after the decision.
// The sequencer emits at most one result per cycle.
// A one-entry output register holds the result; if the receiver stalls,
// the sequencer waits and resumes when that register is taken.
// Reset clears position, buffer fill and the keyframe flag, and restores
// the register defaults (15360 and 8192).
module media_tag_packetizer_core import mtp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [24:0] tag_size, [48:25] header_len, [55:49] zero
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// [0] func, [1] is_keyframe
	input  logic [IN_USER_W-1:0]  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [31:0] packet_pos, [47:32] packet_len
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// [0] continuation, [1] size_error
	output logic [OUT_USER_W-1:0] m_axis_tuser,
	output logic                  m_axis_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	ctl_cmd_t   cmd;
	dp_status_t st;
	logic [POS_W-1:0] pkt_pos;
	logic [LEN_W-1:0] pkt_len;
	logic             cont;
	logic             size_err;

	assign cfg_ready = 1'b1;

	mtp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	mtp_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.st               (st),
		.in_func          (s_axis_tuser[0]),
		.in_tag_size      (s_axis_tdata[TAG_SIZE_W-1:0]),
		.in_is_keyframe   (s_axis_tuser[1]),
		.in_header_len    (s_axis_tdata[TAG_SIZE_W+HDR_LEN_W-1:TAG_SIZE_W]),
		.cfg_we           (cfg_valid && cfg_ready),
		.cfg_idx          (cfg_index),
		.cfg_wdata        (cfg_data),
		.out_ready        (m_axis_tready),
		.out_valid        (m_axis_tvalid),
		.out_packet_pos   (pkt_pos),
		.out_packet_len   (pkt_len),
		.out_continuation (cont),
		.out_is_last      (m_axis_tlast),
		.out_size_error   (size_err)
	);

	assign m_axis_tdata = {pkt_len, pkt_pos};
	assign m_axis_tuser = {size_err, cont};

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import mtp_pkg::*;

	localparam bit FN_PUT   = 1'b0;
	localparam bit FN_FLUSH = 1'b1;
	localparam int QUIET_LIMIT = 4000;
	localparam int TAG_MAX = 16777230;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [LEN_W-1:0] len;
		logic             cont;
		logic             last;
		logic             err;
	} pkt_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_valid = 1'b0;
	logic [IN_DATA_W-1:0]  s_data = '0;
	logic [IN_USER_W-1:0]  s_user = '0;
	logic                  m_ready = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_axis_tready;
	logic                  m_axis_tvalid;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;
	logic                  m_axis_tlast;
	logic                  cfg_ready;

	// predicted block state
	logic [POS_W-1:0] stream_pos = '0;
	logic [LEN_W-1:0] fill_bytes = '0;
	bit               seen_key = 1'b0;
	logic [LEN_W-1:0] max_pkt = MAX_PKT_RESET;
	logic [LEN_W-1:0] flush_thr = THR_RESET;

	pkt_t pending_pkts[$];
	pkt_t held;
	bit   held_ok;

	int src_idle = 0;
	int snk_idle = 0;
	int fails = 0;
	int quiet = 0;

	media_tag_packetizer_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_data),
		.s_axis_tuser  (s_user),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------- packet planner ----------------

	function automatic void add_pkt(logic [POS_W-1:0] pos, logic [LEN_W-1:0] len,
			bit cont, bit err);
		if (held_ok)
			pending_pkts.push_back(held);
		held.pos = pos;
		held.len = len;
		held.cont = cont;
		held.last = 1'b0;
		held.err = err;
		held_ok = 1'b1;
	endfunction

	function automatic void drain_fill();
		if (fill_bytes != 0) begin
			add_pkt(stream_pos, fill_bytes, seen_key, 1'b0);
			stream_pos += fill_bytes;
			fill_bytes = '0;
		end
	endfunction

	function automatic void cut_tag(logic [31:0] sz, bit key, logic [31:0] maxp);
		logic [63:0] chunks;
		logic [31:0] left;
		logic [31:0] len;
		bit          head;
		chunks = (64'(sz) + 64'(maxp) - 64'd1) / 64'(maxp);
		if (chunks > MAX_CHUNKS) begin
			add_pkt(stream_pos, '0, 1'b0, 1'b1);
			return;
		end
		left = sz;
		head = 1'b1;
		while (left != 0) begin
			len = (left > maxp) ? maxp : left;
			add_pkt(stream_pos, len[LEN_W-1:0], seen_key && !(head && key), 1'b0);
			stream_pos += len;
			left -= len;
			head = 1'b0;
		end
	endfunction

	function automatic void plan_packets(bit fn, logic [TAG_SIZE_W-1:0] sz, bit key,
			logic [HDR_LEN_W-1:0] hl);
		logic [31:0] maxp;
		logic [31:0] sum;
		held_ok = 1'b0;
		maxp = (max_pkt == 0) ? 32'd1 : 32'(max_pkt);
		sum = 32'(fill_bytes) + 32'(sz);
		if (fn == FN_FLUSH) begin
			drain_fill();
			stream_pos += 32'(hl);
		end else if (key) begin
			seen_key = 1'b1;
			drain_fill();
			cut_tag(32'(sz), 1'b1, maxp);
		end else if (sum > maxp) begin
			drain_fill();
			cut_tag(32'(sz), 1'b0, maxp);
		end else if (sum > 32'(flush_thr)) begin
			drain_fill();
			fill_bytes = sz[LEN_W-1:0];
			if (fill_bytes > flush_thr)
				drain_fill();
		end else begin
			fill_bytes = sum[LEN_W-1:0];
		end
		if (held_ok) begin
			held.last = 1'b1;
			pending_pkts.push_back(held);
		end
	endfunction

	// ---------------- drivers ----------------

	task automatic push_item(bit fn, logic [TAG_SIZE_W-1:0] sz, bit key,
			logic [HDR_LEN_W-1:0] hl);
		@(negedge clk);
		while ($urandom_range(99) < src_idle) begin
			s_valid <= 1'b0;
			@(negedge clk);
		end
		s_valid <= 1'b1;
		s_data <= {{(IN_DATA_W-TAG_SIZE_W-HDR_LEN_W){1'b0}}, hl, sz};
		s_user <= {key, fn};
		do @(posedge clk); while (!s_axis_tready);
		plan_packets(fn, sz, key, hl);
	endtask

	task automatic put_tag(int sz, bit key);
		push_item(FN_PUT, sz[TAG_SIZE_W-1:0], key, HDR_LEN_W'($urandom));
	endtask

	task automatic flush_cmd(logic [HDR_LEN_W-1:0] hl);
		push_item(FN_FLUSH, TAG_SIZE_W'($urandom_range(TAG_MAX)), 1'($urandom), hl);
	endtask

	// stop sending, drain all results, then let a buffered-only item finish
	task automatic settle();
		@(negedge clk);
		s_valid <= 1'b0;
		while (pending_pkts.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_MAX_PKT)
			max_pkt = val;
		else
			flush_thr = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(negedge clk)
		m_ready <= ($urandom_range(99) >= snk_idle);

	// ---------------- result checker ----------------

	always @(posedge clk) begin
		pkt_t got;
		pkt_t want;
		if (arst_n && m_axis_tvalid && m_ready) begin
			got.pos = m_axis_tdata[POS_W-1:0];
			got.len = m_axis_tdata[POS_W+LEN_W-1:POS_W];
			got.cont = m_axis_tuser[0];
			got.err = m_axis_tuser[1];
			got.last = m_axis_tlast;
			if (pending_pkts.size() == 0) begin
				if (fails < 10)
					$display("unexpected packet: pos=%h len=%0d cont=%b last=%b err=%b",
						got.pos, got.len, got.cont, got.last, got.err);
				fails++;
			end else begin
				want = pending_pkts.pop_front();
				if (got !== want) begin
					if (fails < 10)
						$display("mismatch: exp pos=%h len=%0d cont=%b last=%b err=%b / %s",
							want.pos, want.len, want.cont, want.last, want.err,
							$sformatf("got pos=%h len=%0d cont=%b last=%b err=%b",
							got.pos, got.len, got.cont, got.last, got.err));
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready) ||
					(cfg_valid && cfg_ready)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("FAILURE");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	// ---------------- tests ----------------

	task automatic test_default_regs();
		flush_cmd(24'd0);
		flush_cmd(24'hFFFFFF);
		put_tag(0, 1'b0);
		put_tag(100, 1'b0);
		put_tag(8000, 1'b0);
		put_tag(200, 1'b0);
		put_tag(0, 1'b1);
		put_tag(40000, 1'b1);
		put_tag(20000, 1'b0);
		put_tag(9000, 1'b0);
		put_tag(50, 1'b0);
		put_tag(TAG_MAX, 1'b1);
		put_tag(10, 1'b0);
		put_tag(63 * 15360, 1'b0);
		put_tag(63 * 15360 + 1, 1'b0);
		put_tag(16777216, 1'b0);
		put_tag(16777215, 1'b0);
		put_tag(300, 1'b0);
		push_item(FN_FLUSH, TAG_SIZE_W'(TAG_MAX), 1'b1, 24'h5A5A5A);
		flush_cmd(24'd0);
	endtask

	task automatic test_reg_extremes();
		settle();
		write_reg(CFG_MAX_PKT, 16'd1);
		write_reg(CFG_FLUSH_THR, 16'd0);
		put_tag(0, 1'b0);
		put_tag(1, 1'b0);
		put_tag(2, 1'b0);
		put_tag(63, 1'b1);
		put_tag(64, 1'b1);
		flush_cmd(24'd5);
		settle();
		write_reg(CFG_MAX_PKT, 16'd0);
		write_reg(CFG_FLUSH_THR, 16'hFFFF);
		put_tag(1, 1'b0);
		put_tag(1, 1'b0);
		put_tag(3, 1'b1);
		put_tag(64, 1'b0);
		flush_cmd(24'd7);
		settle();
		write_reg(CFG_MAX_PKT, 16'hFFFF);
		put_tag(65535, 1'b0);
		put_tag(1, 1'b0);
		put_tag(63 * 65535, 1'b0);
		put_tag(63 * 65535 + 1, 1'b1);
		settle();
		write_reg(CFG_FLUSH_THR, 16'd0);
		put_tag(0, 1'b0);
		put_tag(7, 1'b0);
	endtask

	// fill stays put while the threshold drops under it
	task automatic test_threshold_drop();
		settle();
		write_reg(CFG_MAX_PKT, 16'd1000);
		write_reg(CFG_FLUSH_THR, 16'd900);
		put_tag(800, 1'b0);
		settle();
		write_reg(CFG_FLUSH_THR, 16'd100);
		put_tag(10, 1'b0);
		put_tag(5, 1'b0);
		settle();
		write_reg(CFG_FLUSH_THR, 16'd5);
		put_tag(0, 1'b0);
		flush_cmd(24'd1);
	endtask

	task automatic test_random_traffic();
		int mx;
		int r;
		int sz;
		for (int k = 0; k < 3; k++) begin
			settle();
			case ($urandom_range(3))
				0: write_reg(CFG_MAX_PKT, 16'($urandom_range(1, 64)));
				1: write_reg(CFG_MAX_PKT, 16'($urandom_range(100, 4000)));
				2: write_reg(CFG_MAX_PKT, 16'($urandom_range(1) ? 16'hFFFF : 16'd0));
				default: write_reg(CFG_MAX_PKT, 16'($urandom));
			endcase
			mx = (max_pkt == 0) ? 1 : int'(max_pkt);
			if ($urandom_range(3) == 0)
				write_reg(CFG_FLUSH_THR, 16'($urandom));
			else
				write_reg(CFG_FLUSH_THR, 16'($urandom_range(0, mx)));
			for (int n = 0; n < 46; n++) begin
				r = $urandom_range(99);
				if (r < 10) begin
					flush_cmd(HDR_LEN_W'($urandom));
				end else if (r < 25) begin
					put_tag($urandom_range(0, mx * 8), 1'b1);
				end else if (r < 75) begin
					put_tag($urandom_range(0, mx / 3 + 2), 1'b0);
				end else if (r < 92) begin
					sz = $urandom_range(0, mx * 64);
					put_tag((sz > TAG_MAX) ? TAG_MAX : sz, 1'($urandom_range(3) == 0));
				end else begin
					put_tag($urandom_range(0, TAG_MAX), 1'($urandom));
				end
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		src_idle = 6;
		snk_idle = 86;
		test_default_regs();
		test_reg_extremes();
		test_threshold_drop();
		test_random_traffic();
		src_idle = 86;
		snk_idle = 6;
		test_random_traffic();
		src_idle = 0;
		snk_idle = 0;
		test_random_traffic();
		settle();
		repeat (20) @(posedge clk);
		if (pending_pkts.size() != 0) begin
			$display("%0d expected packets never arrived", pending_pkts.size());
			fails++;
		end
		if (fails == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ files.f @@
design/mtp_pkg.sv
design/mtp_ctrl.sv
design/mtp_dp.sv
design/media_tag_packetizer_core.sv
tb/sv/testbench.sv
